/* rtl/core/mau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared constants, request codes and sequencer states for the modular
// arithmetic unit and its bit-serial multiply-reduce datapath.
// ----------------------------------------------------------------------------
package mau_pkg;

  // Default operand width of the request and result fields.
  localparam int OPERAND_WIDTH_DEF = 62;

  // The fixed prime modulus and the number of bits that hold a residue.
  localparam int          PRIME_W = 30;
  localparam logic [29:0] PRIME   = 30'd1000000007;

  // Exponent used for the inverse request (Fermat's little theorem).
  localparam logic [29:0] INV_EXP = PRIME - 30'd2;

  // Request codes carried on req_type.
  typedef enum logic [1:0] {
    REQ_REDUCE  = 2'd0,
    REQ_MULMOD  = 2'd1,
    REQ_POWMOD  = 2'd2,
    REQ_INVERSE = 2'd3
  } req_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_MUL,
    S_SCAN,
    S_SQR,
    S_MULB,
    S_OUT
  } state_t;

endpackage

/* rtl/core/mau_modmul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial modular multiply-reduce
// Computes (x * y) mod m by scanning the multiplier y one bit per cycle,
// most significant bit first: acc = (2 * acc + bit * x) mod m. The operand
// x must not exceed m, so the running sum stays below 3m and one of three
// candidates is always the reduced value. With x = 1 the unit reduces y.
// ----------------------------------------------------------------------------
module mau_modmul #(
  parameter int W = mau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [W-1:0]             x,
  input  logic [W-1:0]             y,
  input  logic [W-1:0]             m,
  input  logic [$clog2(W+1)-1:0]   nbits,
  output logic                     done,
  output logic [W-1:0]             acc
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  xr;
  logic [W-1:0]  yr;
  logic [W-1:0]  mr;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [W+1:0]  t;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W+1:0]  acc_next;

  // Double the accumulator, add x when the current multiplier bit is set,
  // then fold the sum back below m with one of two subtractions.
  always_comb begin
    t  = {1'b0, acc, 1'b0} + {2'b00, (yr[W-1] ? xr : {W{1'b0}})};
    m1 = {2'b00, mr};
    m2 = {1'b0, mr, 1'b0};
    if (t >= m2) begin
      acc_next = t - m2;
    end else if (t >= m1) begin
      acc_next = t - m1;
    end else begin
      acc_next = t;
    end
  end

  // Control: a launch loads the operands, then one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (go) begin
        busy <= 1'b1;
        cnt  <= nbits;
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: operand registers and the shifting multiplier.
  always_ff @(posedge clk) begin
    if (go) begin
      acc <= '0;
      xr  <= x;
      yr  <= y;
      mr  <= m;
    end else if (busy) begin
      acc <= acc_next[W-1:0];
      yr  <= {yr[W-2:0], 1'b0};
    end
  end

endmodule

/* rtl/core/modular_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Reduce, mulmod, powmod and inverse on one shared bit-serial multiply-reduce
// datapath, driven by a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Signals                                     Transfer when
//  request   start, busy, req_type, operand_a/b,         start && !busy
//            modulus_c
//  result    done, result, error                         done (one cycle)
//
//  Request steps, W = OPERAND_WIDTH:
//    reduce: one reduction pass; mulmod: a reduction pass, then a multiply
//    pass; mulmod with a zero modulus goes straight to the error result.
//    powmod and inverse: reduce the base, then scan the exponent from the top
//    bit (W bits, or 30 for inverse); for every bit after the leading one a
//    square and, for a set bit, a multiply by the base, both over P = 30
//    residue bits, then the result. All passes run on the shared serial
//    multiply-reduce unit; a new request is taken only after the last result.
//  Reset is synchronous and returns the sequencer to idle; busy is high from
//  the cycle after a request transfer through the cycle of its result. The
//  receiver cannot stall: the result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit #(
  parameter int OPERAND_WIDTH = mau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type,
  input  logic [OPERAND_WIDTH-1:0] operand_a,
  input  logic [OPERAND_WIDTH-1:0] operand_b,
  input  logic [OPERAND_WIDTH-1:0] modulus_c,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] result,
  output logic                     error
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam int PW = mau_pkg::PRIME_W;

  localparam logic [W-1:0] PRIME_EXT = {{(W-PW){1'b0}}, mau_pkg::PRIME};
  localparam logic [W-1:0] INV_TOP   = {mau_pkg::INV_EXP, {(W-PW){1'b0}}};

  mau_pkg::state_t state;
  mau_pkg::state_t state_next;
  mau_pkg::req_t   kind;
  mau_pkg::req_t   req_in;

  logic [W-1:0]    expo;
  logic [CW-1:0]   ecnt;
  logic [W-1:0]    modr;
  logic [PW-1:0]   base;
  logic [PW-1:0]   pacc;
  logic            started;
  logic            pbit;
  logic [W-1:0]    res;
  logic            err;
  logic            zero_mod;

  logic            mm_go;
  logic [W-1:0]    mm_x;
  logic [W-1:0]    mm_y;
  logic [W-1:0]    mm_m;
  logic [CW-1:0]   mm_n;
  logic            mm_done;
  logic [W-1:0]    mm_acc;

  assign req_in   = mau_pkg::req_t'(req_type);
  assign zero_mod = (modulus_c == '0);

  // Shared serial multiply-reduce unit.
  mau_modmul #(
    .W(W)
  ) u_modmul (
    .clk   (clk),
    .rst   (rst),
    .go    (mm_go),
    .x     (mm_x),
    .y     (mm_y),
    .m     (mm_m),
    .nbits (mm_n),
    .done  (mm_done),
    .acc   (mm_acc)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mau_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      mau_pkg::S_IDLE: begin
        if (start) begin
          if (req_in == mau_pkg::REQ_MULMOD && zero_mod) begin
            state_next = mau_pkg::S_OUT;
          end else begin
            state_next = mau_pkg::S_RED;
          end
        end
      end
      mau_pkg::S_RED: begin
        if (mm_done) begin
          unique case (kind)
            mau_pkg::REQ_REDUCE: state_next = mau_pkg::S_OUT;
            mau_pkg::REQ_MULMOD: state_next = mau_pkg::S_MUL;
            default:             state_next = mau_pkg::S_SCAN;
          endcase
        end
      end
      mau_pkg::S_MUL: begin
        if (mm_done) begin
          state_next = mau_pkg::S_OUT;
        end
      end
      mau_pkg::S_SCAN: begin
        if (ecnt == '0) begin
          state_next = mau_pkg::S_OUT;
        end else if (started) begin
          state_next = mau_pkg::S_SQR;
        end
      end
      mau_pkg::S_SQR: begin
        if (mm_done) begin
          state_next = pbit ? mau_pkg::S_MULB : mau_pkg::S_SCAN;
        end
      end
      mau_pkg::S_MULB: begin
        if (mm_done) begin
          state_next = mau_pkg::S_SCAN;
        end
      end
      mau_pkg::S_OUT: begin
        state_next = mau_pkg::S_IDLE;
      end
      default: begin
        state_next = mau_pkg::S_IDLE;
      end
    endcase
  end

  // Launches of the multiply-reduce unit and its operand selection.
  always_comb begin
    mm_go = 1'b0;
    mm_x  = '0;
    mm_y  = expo;
    mm_m  = modr;
    mm_n  = CW'(W);
    unique case (state)
      mau_pkg::S_IDLE: begin
        // First pass reduces operand_a by the selected modulus.
        if (start && !(req_in == mau_pkg::REQ_MULMOD && zero_mod)) begin
          mm_go = 1'b1;
          mm_x  = W'(1);
          mm_y  = operand_a;
          mm_m  = (req_in == mau_pkg::REQ_MULMOD) ? modulus_c : PRIME_EXT;
        end
      end
      mau_pkg::S_RED: begin
        // Mulmod second pass: reduced multiplicand times operand_b.
        if (mm_done && kind == mau_pkg::REQ_MULMOD) begin
          mm_go = 1'b1;
          mm_x  = mm_acc;
          mm_y  = expo;
        end
      end
      mau_pkg::S_SCAN: begin
        // Square the running power once the leading one has been seen.
        if (ecnt != '0 && started) begin
          mm_go = 1'b1;
          mm_x  = {{(W-PW){1'b0}}, pacc};
          mm_y  = {pacc, {(W-PW){1'b0}}};
          mm_m  = PRIME_EXT;
          mm_n  = CW'(PW);
        end
      end
      mau_pkg::S_SQR: begin
        // Multiply by the base when the exponent bit was set.
        if (mm_done && pbit) begin
          mm_go = 1'b1;
          mm_x  = {{(W-PW){1'b0}}, base};
          mm_y  = {mm_acc[PW-1:0], {(W-PW){1'b0}}};
          mm_m  = PRIME_EXT;
          mm_n  = CW'(PW);
        end
      end
      default: begin
        mm_go = 1'b0;
      end
    endcase
  end

  // Request registers, exponent shifter and running power.
  always_ff @(posedge clk) begin
    case (state)
      mau_pkg::S_IDLE: begin
        if (start) begin
          kind <= req_in;
          modr <= (req_in == mau_pkg::REQ_MULMOD) ? modulus_c : PRIME_EXT;
          expo <= (req_in == mau_pkg::REQ_INVERSE) ? INV_TOP : operand_b;
          ecnt <= (req_in == mau_pkg::REQ_INVERSE) ? CW'(PW) : CW'(W);
          res  <= '0;
          err  <= (req_in == mau_pkg::REQ_MULMOD) && zero_mod;
        end
      end
      mau_pkg::S_RED: begin
        if (mm_done) begin
          res     <= mm_acc;
          base    <= mm_acc[PW-1:0];
          pacc    <= PW'(1);
          started <= 1'b0;
        end
      end
      mau_pkg::S_MUL: begin
        if (mm_done) begin
          res <= mm_acc;
        end
      end
      mau_pkg::S_SCAN: begin
        if (ecnt == '0) begin
          res <= {{(W-PW){1'b0}}, pacc};
        end else begin
          expo <= {expo[W-2:0], 1'b0};
          ecnt <= ecnt - CW'(1);
          pbit <= expo[W-1];
          // The leading one turns the running power into the base directly.
          if (!started && expo[W-1]) begin
            pacc    <= base;
            started <= 1'b1;
          end
        end
      end
      mau_pkg::S_SQR, mau_pkg::S_MULB: begin
        if (mm_done) begin
          pacc <= mm_acc[PW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign busy   = (state != mau_pkg::S_IDLE);
  assign done   = (state == mau_pkg::S_OUT);
  assign result = res;
  assign error  = err;

  // A transferred request always makes the unit busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transfer did not start work");

  // After a result the unit is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("unit still busy after result");

  // An error result is zero and comes only from a mulmod request.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (result == '0 && kind == mau_pkg::REQ_MULMOD))
    else $error("error result is not a zero-modulus mulmod");

  // Results of the prime-modulus operations are fully reduced.
  a_prime_range: assert property (@(posedge clk) disable iff (rst)
    (done && kind != mau_pkg::REQ_MULMOD) |-> (result < PRIME_EXT))
    else $error("prime-modulus result not reduced");

  // The serial unit is never launched while its result is still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (mm_go && state != mau_pkg::S_IDLE) |-> mm_done || state == mau_pkg::S_SCAN)
    else $error("multiply-reduce launched while running");

endmodule

/* tb/tb_modular_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives reduce, mulmod, powmod and inverse requests through the command
// interface, corner cases first, then in random bursts. Each accepted request
// is predicted with wide integer arithmetic, and the predicted residue and
// error flag are compared with every result that the unit strobes out.
// ----------------------------------------------------------------------------

// Holds the residues still owed by the unit and checks each result in order.
class mau_result_scoreboard;

  typedef struct {
    logic [61:0] residue;
    logic        err;
    mau_pkg::req_t kind;
  } residue_t;

  residue_t owed_residues[$];
  int       mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Base raised to an exponent modulo the prime, least significant bit first.
  function automatic logic [61:0] pow_prime(logic [61:0] base, logic [61:0] expo);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq  = {2'b00, base} % mau_pkg::PRIME;
    for (int i = 0; i < 62; i++) begin
      if (expo[i]) begin
        acc = (acc * sq) % mau_pkg::PRIME;
      end
      sq = (sq * sq) % mau_pkg::PRIME;
    end
    return acc[61:0];
  endfunction

  // Full product reduced by the request modulus.
  function automatic logic [61:0] mul_mod(logic [61:0] a, logic [61:0] b,
                                          logic [61:0] m);
    logic [127:0] prod;
    prod = {66'd0, a} * {66'd0, b};
    prod = prod % {66'd0, m};
    return prod[61:0];
  endfunction

  // Notes an accepted request together with the result it must produce.
  function void note_request(mau_pkg::req_t kind, logic [61:0] a, logic [61:0] b,
                             logic [61:0] c);
    residue_t r;
    r.kind = kind;
    r.err  = 1'b0;
    case (kind)
      mau_pkg::REQ_REDUCE: begin
        r.residue = a % mau_pkg::PRIME;
      end
      mau_pkg::REQ_MULMOD: begin
        if (c == '0) begin
          r.residue = '0;
          r.err     = 1'b1;
        end else begin
          r.residue = mul_mod(a, b, c);
        end
      end
      mau_pkg::REQ_POWMOD: begin
        r.residue = pow_prime(a, b);
      end
      default: begin
        r.residue = pow_prime(a, {32'd0, mau_pkg::INV_EXP});
      end
    endcase
    owed_residues.insert(owed_residues.size(), r);
  endfunction

  function int pending();
    return owed_residues.size();
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Compares one strobed result with the oldest owed residue.
  task check_result(logic [61:0] res, logic err);
    residue_t r;
    if (owed_residues.size() == 0) begin
      report_mismatch($sformatf("unrequested result %0d error %0b", res, err));
      return;
    end
    r = owed_residues.pop_front();
    if (res !== r.residue) begin
      report_mismatch($sformatf("%s result %0d, predicted %0d",
                                r.kind.name(), res, r.residue));
    end
    if (err !== r.err) begin
      report_mismatch($sformatf("%s error %0b, predicted %0b",
                                r.kind.name(), err, r.err));
    end
  endtask

endclass

module tb_modular_arithmetic_unit;

  localparam int          W        = mau_pkg::OPERAND_WIDTH_DEF;
  localparam logic [61:0] ALL_ONES = '1;
  localparam logic [61:0] P62      = {32'd0, mau_pkg::PRIME};
  localparam int          RANDOM_ITEMS = 900;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  logic [1:0]   req_type;
  logic [W-1:0] operand_a;
  logic [W-1:0] operand_b;
  logic [W-1:0] modulus_c;
  logic         done;
  logic [W-1:0] result;
  logic         error;

  mau_result_scoreboard sb = new();

  modular_arithmetic_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .modulus_c (modulus_c),
    .done      (done),
    .result    (result),
    .error     (error)
  );

  // Free-running clock with a 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(result, error);
    end
  end

  // Presents one request and holds it until the unit takes the transfer.
  task automatic send_request(mau_pkg::req_t kind, logic [61:0] a, logic [61:0] b,
                              logic [61:0] c);
    @(negedge clk);
    start     <= 1'b1;
    req_type  <= kind;
    operand_a <= a;
    operand_b <= b;
    modulus_c <= c;
    do begin
      @(posedge clk);
    end while (busy);
    sb.note_request(kind, a, b, c);
  endtask

  // Lowers start for a number of cycles.
  task automatic idle_sender(int unsigned cycles);
    if (cycles == 0) begin
      return;
    end
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Operand with a mix of full-width, narrow, edge and prime-related values.
  function automatic logic [61:0] random_operand();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: return raw[61:0] & (ALL_ONES >> $urandom_range(0, 61));
      2:    return ALL_ONES;
      3:    return P62 * 62'($urandom_range(0, 1000)) + 62'($urandom_range(0, 2));
      4:    return 62'($urandom_range(0, 15));
      default: return raw[61:0];
    endcase
  endfunction

  // Random request; powmod exponents mostly get a random bit length.
  task automatic send_random_request();
    mau_pkg::req_t kind;
    logic [61:0] a;
    logic [61:0] b;
    logic [61:0] c;
    logic [63:0] raw;
    kind = mau_pkg::req_t'($urandom_range(0, 3));
    a    = random_operand();
    b    = random_operand();
    c    = random_operand();
    if (kind == mau_pkg::REQ_POWMOD && $urandom_range(0, 3) != 0) begin
      raw = {$urandom, $urandom};
      b   = raw[61:0] & (ALL_ONES >> $urandom_range(0, 61));
    end
    if (kind == mau_pkg::REQ_MULMOD && $urandom_range(0, 15) == 0) begin
      c = '0;
    end
    send_request(kind, a, b, c);
  endtask

  // Reset, directed corner cases, then random bursts.
  initial begin
    int unsigned sent;
    int unsigned burst;
    rst       = 1'b1;
    start     = 1'b0;
    req_type  = mau_pkg::REQ_REDUCE;
    operand_a = '0;
    operand_b = '0;
    modulus_c = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reduce at the field extremes and around multiples of the prime.
    send_request(mau_pkg::REQ_REDUCE, '0, '0, '0);
    send_request(mau_pkg::REQ_REDUCE, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(mau_pkg::REQ_REDUCE, P62, '0, '0);
    send_request(mau_pkg::REQ_REDUCE, P62 - 62'd1, '0, '0);
    send_request(mau_pkg::REQ_REDUCE, P62 * 62'd4000000007, '0, '0);
    // Mulmod with zero and unit moduli, and at full width.
    send_request(mau_pkg::REQ_MULMOD, ALL_ONES, ALL_ONES, '0);
    send_request(mau_pkg::REQ_MULMOD, ALL_ONES, ALL_ONES, 62'd1);
    send_request(mau_pkg::REQ_MULMOD, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(mau_pkg::REQ_MULMOD, ALL_ONES, ALL_ONES, ALL_ONES - 62'd1);
    send_request(mau_pkg::REQ_MULMOD, '0, ALL_ONES, 62'd12345);
    send_request(mau_pkg::REQ_MULMOD, ALL_ONES, '0, 62'd12345);
    send_request(mau_pkg::REQ_MULMOD, ALL_ONES - 62'd3, ALL_ONES >> 1,
                 (62'd1 << 61) + 62'd1);
    idle_sender(3);
    // Powmod: zero exponent, zero base, full width, Fermat and prime multiples.
    send_request(mau_pkg::REQ_POWMOD, P62, '0, '0);
    send_request(mau_pkg::REQ_POWMOD, '0, '0, '0);
    send_request(mau_pkg::REQ_POWMOD, '0, 62'd5, '0);
    send_request(mau_pkg::REQ_POWMOD, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(mau_pkg::REQ_POWMOD, 62'd2, P62 - 62'd1, '0);
    send_request(mau_pkg::REQ_POWMOD, P62 * 62'd3, 62'd7, '0);
    // Inverse of zero, one, two, the prime, one below the prime and the top value.
    send_request(mau_pkg::REQ_INVERSE, '0, '0, '0);
    send_request(mau_pkg::REQ_INVERSE, 62'd1, ALL_ONES, ALL_ONES);
    send_request(mau_pkg::REQ_INVERSE, P62, '0, '0);
    send_request(mau_pkg::REQ_INVERSE, ALL_ONES, '0, '0);
    send_request(mau_pkg::REQ_INVERSE, 62'd2, '0, '0);
    send_request(mau_pkg::REQ_INVERSE, P62 - 62'd1, '0, '0);
    drain_results();

    // Random bursts with random gaps; once halfway, let the unit run dry.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        send_random_request();
        sent++;
        if (sent == RANDOM_ITEMS / 2) begin
          drain_results();
        end
      end
      case ($urandom_range(0, 15))
        0, 1, 2, 3: ;
        4:       idle_sender($urandom_range(50, 600));
        default: idle_sender($urandom_range(1, 8));
      endcase
    end
    drain_results();
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung unit.
  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mau_pkg.sv
rtl/core/mau_modmul.sv
rtl/core/modular_arithmetic_unit.sv
tb/tb_modular_arithmetic_unit.sv
